// ===== rtl/ddo_pkg.sv =====
package ddo_pkg;

	// item opcodes
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_CMD  = 1'b1;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 24;
	localparam logic [CFG_IDX_W-1:0] REG_WHEEL_RADIUS   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INV_WHEEL_SEP  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_WHEEL_SEP = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INV_WHEEL_RAD  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CMD_TIMEOUT    = 3'd4;

	// register reset values
	localparam logic [15:0] WHEEL_RADIUS_RST   = 16'd4915;
	localparam logic [23:0] INV_WHEEL_SEP_RST  = 24'd192752;
	localparam logic [15:0] HALF_WHEEL_SEP_RST = 16'd11141;
	localparam logic [23:0] INV_WHEEL_RAD_RST  = 24'd873813;
	localparam logic [20:0] CMD_TIMEOUT_RST    = 21'd629146;

	localparam int ANGLE_STEPS_DEF = 20;
	localparam logic signed [32:0] CORDIC_KINV = 33'sd652032874;
	localparam logic signed [31:0] RAD_TO_BAM  = 32'sd683565276;
	localparam logic [20:0] TIME_MAX = 21'h1FFFFF;

	// multiplier operand and product widths
	localparam int MUL_A_W = 50;
	localparam int MUL_B_W = 32;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	function automatic logic [29:0] atan_bam(input logic [4:0] i);
		logic [29:0] r;
		begin
			case (i)
				5'd0:  r = 30'd536870912;
				5'd1:  r = 30'd316933406;
				5'd2:  r = 30'd167458907;
				5'd3:  r = 30'd85004756;
				5'd4:  r = 30'd42667331;
				5'd5:  r = 30'd21354465;
				5'd6:  r = 30'd10679838;
				5'd7:  r = 30'd5340245;
				5'd8:  r = 30'd2670163;
				5'd9:  r = 30'd1335087;
				5'd10: r = 30'd667544;
				5'd11: r = 30'd333772;
				5'd12: r = 30'd166886;
				5'd13: r = 30'd83443;
				5'd14: r = 30'd41722;
				5'd15: r = 30'd20861;
				5'd16: r = 30'd10430;
				5'd17: r = 30'd5215;
				5'd18: r = 30'd2608;
				5'd19: r = 30'd1304;
				5'd20: r = 30'd652;
				5'd21: r = 30'd326;
				5'd22: r = 30'd163;
				5'd23: r = 30'd81;
				5'd24: r = 30'd41;
				5'd25: r = 30'd20;
				5'd26: r = 30'd10;
				5'd27: r = 30'd5;
				5'd28: r = 30'd3;
				5'd29: r = 30'd1;
				5'd30: r = 30'd1;
				default: r = 30'd0;
			endcase
			return r;
		end
	endfunction

	function automatic logic signed [23:0] sat24(input logic signed [33:0] v);
		logic signed [23:0] r;
		begin
			if (v > 34'sd8388607)
				r = 24'sh7FFFFF;
			else if (v < -34'sd8388608)
				r = 24'sh800000;
			else
				r = v[23:0];
			return r;
		end
	endfunction

endpackage

// ===== rtl/ddo_in_if.sv =====
interface ddo_in_if;
	logic valid;
	logic ready;
	logic op;
	logic signed [23:0] left_wheel_rate;
	logic signed [23:0] right_wheel_rate;
	logic [20:0] elapsed;
	logic signed [23:0] cmd_linear;
	logic signed [23:0] cmd_angular;

	modport source(output valid, op, left_wheel_rate, right_wheel_rate, elapsed,
		cmd_linear, cmd_angular, input ready);
	modport sink(input valid, op, left_wheel_rate, right_wheel_rate, elapsed,
		cmd_linear, cmd_angular, output ready);
endinterface

// ===== rtl/ddo_out_if.sv =====
interface ddo_out_if;
	logic valid;
	logic ready;
	logic signed [47:0] pos_x;
	logic signed [47:0] pos_y;
	logic [31:0] heading;
	logic signed [23:0] linear_velocity;
	logic signed [23:0] angular_velocity;
	logic signed [23:0] left_drive;
	logic signed [23:0] right_drive;
	logic timed_out;

	modport source(output valid, pos_x, pos_y, heading, linear_velocity,
		angular_velocity, left_drive, right_drive, timed_out, input ready);
	modport sink(input valid, pos_x, pos_y, heading, linear_velocity,
		angular_velocity, left_drive, right_drive, timed_out, output ready);
endinterface

// ===== rtl/ddo_mul.sv =====
// Signed multiplier, 16-bit digit of b per cycle: high (signed) digit first.
module ddo_mul (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [ddo_pkg::MUL_A_W-1:0] a,
	input  logic signed [ddo_pkg::MUL_B_W-1:0] b,
	output logic done,
	output logic signed [ddo_pkg::MUL_P_W-1:0] prod
);
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_HI   = 2'd1;
	localparam logic [1:0] PH_LO   = 2'd2;
	localparam int PP_W = ddo_pkg::MUL_A_W + 17;

	logic [1:0] ph_q;
	logic done_q;
	logic signed [ddo_pkg::MUL_A_W-1:0] a_q;
	logic [15:0] blo_q;
	logic [15:0] bhi_q;
	logic signed [ddo_pkg::MUL_P_W-1:0] acc_q;
	logic signed [16:0] dig;
	logic signed [PP_W-1:0] pp;
	logic signed [ddo_pkg::MUL_P_W-1:0] pp_ext;

	always_comb begin
		dig = (ph_q == PH_HI) ? $signed({bhi_q[15], bhi_q}) : $signed({1'b0, blo_q});
		pp = a_q * dig;
		pp_ext = {{(ddo_pkg::MUL_P_W-PP_W){pp[PP_W-1]}}, pp};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= (ph_q == PH_LO);
			unique case (ph_q)
				PH_IDLE: if (start) ph_q <= PH_HI;
				PH_HI:   ph_q <= PH_LO;
				PH_LO:   ph_q <= PH_IDLE;
				default: ph_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ph_q == PH_IDLE && start) begin
			a_q <= a;
			blo_q <= b[15:0];
			bhi_q <= b[31:16];
		end
		if (ph_q == PH_HI)
			acc_q <= pp_ext;
		else if (ph_q == PH_LO)
			acc_q <= (acc_q <<< 16) + pp_ext;
	end

	assign done = done_q;
	assign prod = acc_q;
endmodule

// ===== rtl/ddo_cordic.sv =====
// Rotation-mode CORDIC, one micro-rotation per cycle, quadrant folded in after.
module ddo_cordic #(
	parameter int ANGLE_STEPS = ddo_pkg::ANGLE_STEPS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [31:0] heading,
	output logic done,
	output logic signed [31:0] cos_v,
	output logic signed [31:0] sin_v
);
	localparam int CW = $clog2(ANGLE_STEPS + 1);

	logic busy_q;
	logic done_q;
	logic [CW-1:0] it_q;
	logic [1:0] q_q;
	logic signed [32:0] x_q;
	logic signed [32:0] y_q;
	logic signed [33:0] z_q;
	logic [31:0] hq;
	logic [31:0] resid;
	logic [4:0] idx;
	logic signed [33:0] at;

	always_comb begin
		hq = heading + 32'h2000_0000;
		resid = heading - {hq[31:30], 30'd0};
		idx = 5'(it_q);
		at = $signed({4'd0, ddo_pkg::atan_bam(idx)});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			it_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			it_q <= '0;
		end else if (busy_q) begin
			it_q <= it_q + 1'b1;
			if (it_q == CW'(ANGLE_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= hq[31:30];
			x_q <= ddo_pkg::CORDIC_KINV;
			y_q <= '0;
			z_q <= {{2{resid[31]}}, resid};
		end else if (busy_q) begin
			if (!z_q[33]) begin
				x_q <= x_q - (y_q >>> idx);
				y_q <= y_q + (x_q >>> idx);
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + (y_q >>> idx);
				y_q <= y_q - (x_q >>> idx);
				z_q <= z_q + at;
			end
		end
	end

	always_comb begin
		case (q_q)
			2'd0: begin cos_v = x_q[31:0];    sin_v = y_q[31:0];    end
			2'd1: begin cos_v = -y_q[31:0];   sin_v = x_q[31:0];    end
			2'd2: begin cos_v = -x_q[31:0];   sin_v = -y_q[31:0];   end
			default: begin cos_v = y_q[31:0]; sin_v = -x_q[31:0];   end
		endcase
	end

	assign done = done_q;
endmodule

// ===== rtl/diff_drive_odometry_unit.sv =====
// Differential-drive odometry and wheel drive command unit.
// Channel "item" (valid/ready) carries either an odometry tick (op = tick:
// wheel rates and elapsed time) or a velocity command (op = cmd). Channel
// "result" returns exactly one beat per item: pose, heading, velocity
// estimates, wheel drive setpoints and the timeout flag.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// write it only while idle, as the block itself does not enforce this. All
// products run through one shared signed multiplier that takes a 16-bit
// digit per cycle; each product is issued, makes two digit passes (high,
// then low) and is written back. A tick needs twelve products and a command
// three; after the last one the sequencer commits the item and then loads
// the output register. item.ready is high only while the sequencer is idle,
// so the next item is not taken before the last one has been loaded into
// the output register. The heading CORDIC runs alongside the first ten
// products and is finished before the position products are issued.
// The result sits in an output register, so a stalled receiver holds the
// beat there while the next item is already accepted and worked on; that
// item waits only at the end if the register is still full.
// Reset clears pose, heading, targets, velocities, timer and loads the
// default geometry registers.
module diff_drive_odometry_unit #(
	parameter int ANGLE_STEPS = ddo_pkg::ANGLE_STEPS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [ddo_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ddo_pkg::CFG_DATA_W-1:0] cfg_data,
	ddo_in_if.sink item,
	ddo_out_if.source result
);
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_ISSUE  = 3'd1;
	localparam logic [2:0] S_WAIT   = 3'd2;
	localparam logic [2:0] S_COMMIT = 3'd3;
	localparam logic [2:0] S_FINISH = 3'd4;

	// sequencer steps, one product each
	localparam logic [3:0] T_SR   = 4'd0;
	localparam logic [3:0] T_DR   = 4'd1;
	localparam logic [3:0] T_DQ   = 4'd2;
	localparam logic [3:0] T_DA   = 4'd3;
	localparam logic [3:0] T_DH   = 4'd4;
	localparam logic [3:0] T_LIN  = 4'd5;
	localparam logic [3:0] T_ANG1 = 4'd6;
	localparam logic [3:0] T_ANG  = 4'd7;
	localparam logic [3:0] T_LDRV = 4'd8;
	localparam logic [3:0] T_RDRV = 4'd9;
	localparam logic [3:0] T_PX   = 4'd10;
	localparam logic [3:0] T_PY   = 4'd11;
	localparam logic [3:0] C_TURN = 4'd12;

	localparam int AW = ddo_pkg::MUL_A_W;
	localparam int BW = ddo_pkg::MUL_B_W;

	logic [2:0] state_q;
	logic [3:0] step_q;

	// configuration
	logic [15:0] wrad_q;
	logic [23:0] inv_sep_q;
	logic [15:0] half_sep_q;
	logic [23:0] inv_wrad_q;
	logic [20:0] timeout_q;

	// architectural state
	logic signed [47:0] posx_q;
	logic signed [47:0] posy_q;
	logic [31:0] head_q;
	logic signed [23:0] lt_q;
	logic signed [23:0] rt_q;
	logic [20:0] tsc_q;
	logic signed [23:0] lin_q;
	logic signed [23:0] ang_q;
	logic tout_q;

	// captured item and scratch
	logic op_q;
	logic signed [23:0] wl_q;
	logic signed [23:0] wr_q;
	logic [20:0] st_q;
	logic signed [23:0] vr_q;
	logic signed [23:0] va_q;
	logic [36:0] sr_q;
	logic signed [32:0] dr_q;
	logic signed [33:0] dq_q;
	logic signed [49:0] da_q;
	logic [31:0] dh_q;
	logic signed [33:0] ang1_q;
	logic signed [23:0] ldrv_q;
	logic signed [23:0] rdrv_q;

	// output register
	logic res_valid_q;
	logic signed [47:0] res_px_q;
	logic signed [47:0] res_py_q;
	logic [31:0] res_head_q;
	logic signed [23:0] res_lin_q;
	logic signed [23:0] res_ang_q;
	logic signed [23:0] res_ldrv_q;
	logic signed [23:0] res_rdrv_q;
	logic res_tout_q;

	logic accept;
	logic mul_start;
	logic mul_done;
	logic signed [AW-1:0] mul_a;
	logic signed [BW-1:0] mul_b;
	logic signed [ddo_pkg::MUL_P_W-1:0] prod;
	logic cor_done;
	logic signed [31:0] cos_v;
	logic signed [31:0] sin_v;
	logic signed [24:0] wsum;
	logic signed [24:0] wdiff;
	logic signed [24:0] turn;
	logic [21:0] tsum;
	logic [20:0] tnew;
	logic res_free;
	logic last_step;

	assign accept = item.valid && item.ready;
	assign item.ready = (state_q == S_IDLE);
	assign res_free = !res_valid_q || result.ready;
	// the product that closes the item: the second drive for a command, y for a tick
	assign last_step = (step_q == T_PY) ||
		(step_q == T_RDRV && op_q == ddo_pkg::OP_CMD);

	always_comb begin
		wsum = 25'(wl_q) + 25'(wr_q);
		wdiff = 25'(wr_q) - 25'(wl_q);
		turn = prod[40:16];
		tsum = {1'b0, tsc_q} + {1'b0, st_q};
		tnew = tsum[21] ? ddo_pkg::TIME_MAX : tsum[20:0];
	end

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (step_q)
			T_SR:   begin mul_a = AW'(st_q);          mul_b = BW'(wrad_q); end
			T_DR:   begin mul_a = AW'(sr_q);          mul_b = BW'(wsum); end
			T_DQ:   begin mul_a = AW'(sr_q);          mul_b = BW'(wdiff); end
			T_DA:   begin mul_a = AW'(dq_q);          mul_b = BW'(inv_sep_q); end
			T_DH:   begin mul_a = da_q;               mul_b = ddo_pkg::RAD_TO_BAM; end
			T_LIN:  begin mul_a = AW'(wsum);          mul_b = BW'(wrad_q); end
			T_ANG1: begin mul_a = AW'(wdiff);         mul_b = BW'(wrad_q); end
			T_ANG:  begin mul_a = AW'(ang1_q);        mul_b = BW'(inv_sep_q); end
			T_LDRV: begin mul_a = AW'(lt_q);          mul_b = BW'(inv_wrad_q); end
			T_RDRV: begin mul_a = AW'(rt_q);          mul_b = BW'(inv_wrad_q); end
			T_PX:   begin mul_a = AW'(dr_q);          mul_b = cos_v; end
			T_PY:   begin mul_a = AW'(dr_q);          mul_b = sin_v; end
			C_TURN: begin mul_a = AW'(va_q);          mul_b = BW'(half_sep_q); end
			default: begin mul_a = '0;                mul_b = '0; end
		endcase
	end

	// the first position step (x) waits on the CORDIC
	assign mul_start = (state_q == S_ISSUE) && ((step_q != T_PX) || cor_done);

	ddo_mul u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.start(mul_start),
		.a(mul_a),
		.b(mul_b),
		.done(mul_done),
		.prod(prod)
	);

	ddo_cordic #(.ANGLE_STEPS(ANGLE_STEPS)) u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.start(accept && item.op == ddo_pkg::OP_TICK),
		.heading(head_q),
		.done(cor_done),
		.cos_v(cos_v),
		.sin_v(sin_v)
	);

	// sequencer, configuration and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q <= T_SR;
			wrad_q <= ddo_pkg::WHEEL_RADIUS_RST;
			inv_sep_q <= ddo_pkg::INV_WHEEL_SEP_RST;
			half_sep_q <= ddo_pkg::HALF_WHEEL_SEP_RST;
			inv_wrad_q <= ddo_pkg::INV_WHEEL_RAD_RST;
			timeout_q <= ddo_pkg::CMD_TIMEOUT_RST;
			posx_q <= '0;
			posy_q <= '0;
			head_q <= '0;
			lt_q <= '0;
			rt_q <= '0;
			tsc_q <= '0;
			lin_q <= '0;
			ang_q <= '0;
			tout_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					ddo_pkg::REG_WHEEL_RADIUS:   wrad_q <= cfg_data[15:0];
					ddo_pkg::REG_INV_WHEEL_SEP:  inv_sep_q <= cfg_data;
					ddo_pkg::REG_HALF_WHEEL_SEP: half_sep_q <= cfg_data[15:0];
					ddo_pkg::REG_INV_WHEEL_RAD:  inv_wrad_q <= cfg_data;
					ddo_pkg::REG_CMD_TIMEOUT:    timeout_q <= cfg_data[20:0];
					default: ;
				endcase
			end

			// load a finished beat, or drop the one the receiver has taken
			if (state_q == S_FINISH && res_free)
				res_valid_q <= 1'b1;
			else if (result.ready)
				res_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						step_q <= (item.op == ddo_pkg::OP_CMD) ? C_TURN : T_SR;
						state_q <= S_ISSUE;
					end
				end
				S_ISSUE: begin
					if (mul_start)
						state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (mul_done) begin
						// write back the product and advance
						state_q <= last_step ? S_COMMIT : S_ISSUE;
						step_q <= (step_q == C_TURN) ? T_LDRV : step_q + 4'd1;
						case (step_q)
							T_LIN: lin_q <= ddo_pkg::sat24({{9{prod[41]}}, prod[41:17]});
							T_ANG: ang_q <= ddo_pkg::sat24(prod[57:24]);
							T_PX: posx_q <= posx_q + {{21{prod[64]}}, prod[64:38]};
							T_PY: posy_q <= posy_q + {{21{prod[64]}}, prod[64:38]};
							C_TURN: begin
								lt_q <= ddo_pkg::sat24(34'(vr_q) - 34'(turn));
								rt_q <= ddo_pkg::sat24(34'(vr_q) + 34'(turn));
							end
							default: ;
						endcase
					end
				end
				S_COMMIT: begin
					// heading, command timer and timeout take effect once
					if (op_q == ddo_pkg::OP_TICK) begin
						head_q <= head_q + dh_q;
						tsc_q <= tnew;
						if (tnew > timeout_q) begin
							lt_q <= '0;
							rt_q <= '0;
							tout_q <= 1'b1;
						end else begin
							tout_q <= 1'b0;
						end
					end else begin
						tsc_q <= '0;
						tout_q <= 1'b0;
					end
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					// hold until the output register is free
					if (res_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// captured item, scratch products and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= item.op;
			wl_q <= item.left_wheel_rate;
			wr_q <= item.right_wheel_rate;
			st_q <= item.elapsed;
			vr_q <= item.cmd_linear;
			va_q <= item.cmd_angular;
		end
		if (state_q == S_WAIT && mul_done) begin
			case (step_q)
				T_SR:   sr_q <= prod[36:0];
				T_DR:   dr_q <= prod[61:29];
				T_DQ:   dq_q <= prod[61:28];
				T_DA:   da_q <= prod[57:8];
				T_DH:   dh_q <= prod[63:32];
				T_ANG1: ang1_q <= prod[41:8];
				T_LDRV: ldrv_q <= ddo_pkg::sat24({prod[48], prod[48:16]});
				T_RDRV: rdrv_q <= ddo_pkg::sat24({prod[48], prod[48:16]});
				default: ;
			endcase
		end
		if (state_q == S_FINISH && res_free) begin
			res_px_q <= posx_q;
			res_py_q <= posy_q;
			res_head_q <= head_q;
			res_lin_q <= lin_q;
			res_ang_q <= ang_q;
			res_ldrv_q <= ldrv_q;
			res_rdrv_q <= rdrv_q;
			res_tout_q <= tout_q;
		end
	end

	assign result.valid = res_valid_q;
	assign result.pos_x = res_px_q;
	assign result.pos_y = res_py_q;
	assign result.heading = res_head_q;
	assign result.linear_velocity = res_lin_q;
	assign result.angular_velocity = res_ang_q;
	assign result.left_drive = res_ldrv_q;
	assign result.right_drive = res_rdrv_q;
	assign result.timed_out = res_tout_q;

	// a product only completes while the sequencer waits on it
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> state_q == S_WAIT)
		else $error("multiplier finished outside a wait step");

	// sine and cosine must be settled before the position products are issued
	a_cordic_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(mul_start && (step_q == T_PX || step_q == T_PY)) |-> cor_done)
		else $error("position product issued before CORDIC finished");

	// a timed-out tick leaves both wheel targets at zero
	a_timeout_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH && tout_q) |-> (lt_q == '0 && rt_q == '0))
		else $error("targets not cleared after timeout");
endmodule

// ===== verif/diff_drive_odometry_unit_tb.sv =====
`timescale 1ns / 1ps

module diff_drive_odometry_unit_tb;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_PER_PHASE = 460;

	typedef struct {
		logic op;
		logic signed [23:0] left_rate;
		logic signed [23:0] right_rate;
		logic [20:0] elapsed;
		logic signed [23:0] cmd_lin;
		logic signed [23:0] cmd_ang;
	} odo_item_t;

	typedef struct {
		logic signed [47:0] pos_x;
		logic signed [47:0] pos_y;
		logic [31:0] heading;
		logic signed [23:0] lin_vel;
		logic signed [23:0] ang_vel;
		logic signed [23:0] left_drive;
		logic signed [23:0] right_drive;
		logic timed_out;
	} odo_result_t;

	// arctangents of 2^-i as binary angles
	localparam longint ATAN_STEP [0:31] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465, 10679838,
		5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861,
		10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0};

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [ddo_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [ddo_pkg::CFG_DATA_W-1:0] cfg_data;

	ddo_in_if item_bus();
	ddo_out_if result_bus();

	diff_drive_odometry_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item(item_bus),
		.result(result_bus)
	);

	// shadow of the geometry registers
	logic [15:0] geo_radius;
	logic [23:0] geo_inv_sep;
	logic [15:0] geo_half_sep;
	logic [23:0] geo_inv_radius;
	logic [20:0] geo_timeout;

	// shadow of the odometry state
	logic signed [47:0] odo_x;
	logic signed [47:0] odo_y;
	logic [31:0] odo_heading;
	logic signed [23:0] odo_left_target;
	logic signed [23:0] odo_right_target;
	logic [20:0] odo_idle_time;
	logic signed [23:0] odo_lin_vel;
	logic signed [23:0] odo_ang_vel;

	odo_result_t pending_results[$];
	int mismatches = 0;
	int results_seen = 0;
	int ticks_sent = 0;
	int commands_sent = 0;
	int timeouts_seen = 0;
	int cycles = 0;
	int gap_pct = 0;
	int stall_pct = 0;

	// Clock, watchdog
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding", cycles,
				pending_results.size());
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic logic signed [23:0] clamp_q8(input longint v);
		if (v > 64'sd8388607)
			return 24'sh7FFFFF;
		if (v < -64'sd8388608)
			return 24'sh800000;
		return v[23:0];
	endfunction

	// Rotate the unit vector to the heading: quadrant fold first, then the
	// shift-and-add rotations on the residual angle.
	task automatic heading_sincos(input logic [31:0] h, output longint c, output longint s);
		logic [31:0] biased;
		logic [1:0] quad;
		logic [31:0] resid;
		longint x, y, z, nx;
		begin
			biased = h + 32'h2000_0000;
			quad = biased[31:30];
			resid = h - {quad, 30'b0};
			z = longint'(signed'(resid));
			x = 652032874;
			y = 0;
			for (int i = 0; i < ddo_pkg::ANGLE_STEPS_DEF; i++) begin
				if (z >= 0) begin
					nx = x - (y >>> i);
					y = y + (x >>> i);
					z = z - ATAN_STEP[i];
				end else begin
					nx = x + (y >>> i);
					y = y - (x >>> i);
					z = z + ATAN_STEP[i];
				end
				x = nx;
			end
			case (quad)
				2'd0: begin c = x; s = y; end
				2'd1: begin c = -y; s = x; end
				2'd2: begin c = -x; s = -y; end
				default: begin c = y; s = -x; end
			endcase
		end
	endtask

	// Advance the shadow state by one beat and return what the block must report.
	task automatic odometry_predict(input odo_item_t it, output odo_result_t r);
		longint wl, wr, sr, dr, dq, da, c, s, t;
		logic [63:0] turn_bam;
		logic signed [23:0] ld, rd;
		logic tout;
		begin
			tout = 1'b0;
			if (it.op == ddo_pkg::OP_TICK) begin
				wl = it.left_rate;
				wr = it.right_rate;
				sr = longint'(it.elapsed) * longint'(geo_radius);
				dr = (sr * (wl + wr)) >>> 29;
				dq = (sr * (wr - wl)) >>> 28;
				da = (dq * longint'(geo_inv_sep)) >>> 8;
				turn_bam = da * 64'sd683565276;
				heading_sincos(odo_heading, c, s);
				odo_x = odo_x + 48'((dr * c) >>> 38);
				odo_y = odo_y + 48'((dr * s) >>> 38);
				odo_heading = odo_heading + turn_bam[63:32];
				odo_lin_vel = clamp_q8((longint'(geo_radius) * (wl + wr)) >>> 17);
				odo_ang_vel = clamp_q8((((longint'(geo_radius) * (wr - wl)) >>> 8)
					* longint'(geo_inv_sep)) >>> 24);
				// drive comes from the targets before the timeout check
				ld = clamp_q8((longint'(odo_left_target) * longint'(geo_inv_radius)) >>> 16);
				rd = clamp_q8((longint'(odo_right_target) * longint'(geo_inv_radius)) >>> 16);
				t = longint'(odo_idle_time) + longint'(it.elapsed);
				if (t > longint'(ddo_pkg::TIME_MAX))
					t = longint'(ddo_pkg::TIME_MAX);
				odo_idle_time = t[20:0];
				if (odo_idle_time > geo_timeout) begin
					odo_left_target = '0;
					odo_right_target = '0;
					tout = 1'b1;
				end
			end else begin
				t = (longint'(it.cmd_ang) * longint'(geo_half_sep)) >>> 16;
				odo_left_target = clamp_q8(longint'(it.cmd_lin) - t);
				odo_right_target = clamp_q8(longint'(it.cmd_lin) + t);
				odo_idle_time = '0;
				ld = clamp_q8((longint'(odo_left_target) * longint'(geo_inv_radius)) >>> 16);
				rd = clamp_q8((longint'(odo_right_target) * longint'(geo_inv_radius)) >>> 16);
			end
			r.pos_x = odo_x;
			r.pos_y = odo_y;
			r.heading = odo_heading;
			r.lin_vel = odo_lin_vel;
			r.ang_vel = odo_ang_vel;
			r.left_drive = ld;
			r.right_drive = rd;
			r.timed_out = tout;
		end
	endtask

	task automatic report_mismatch(input string field, input logic [63:0] got,
		input logic [63:0] want);
		$display("[%0t] result %0d: %s got %0h expected %0h", $realtime, results_seen,
			field, got, want);
		mismatches++;
	endtask

	// Result side: random stall at the falling edge, check at the rising edge
	always @(negedge clk) begin
		if (arst_n)
			result_bus.ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		odo_result_t want;
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (pending_results.size() == 0) begin
				$display("[%0t] result beat with nothing outstanding", $realtime);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (result_bus.pos_x !== want.pos_x)
					report_mismatch("pos_x", 64'(result_bus.pos_x), 64'(want.pos_x));
				if (result_bus.pos_y !== want.pos_y)
					report_mismatch("pos_y", 64'(result_bus.pos_y), 64'(want.pos_y));
				if (result_bus.heading !== want.heading)
					report_mismatch("heading", 64'(result_bus.heading), 64'(want.heading));
				if (result_bus.linear_velocity !== want.lin_vel)
					report_mismatch("linear_velocity", 64'(result_bus.linear_velocity),
						64'(want.lin_vel));
				if (result_bus.angular_velocity !== want.ang_vel)
					report_mismatch("angular_velocity", 64'(result_bus.angular_velocity),
						64'(want.ang_vel));
				if (result_bus.left_drive !== want.left_drive)
					report_mismatch("left_drive", 64'(result_bus.left_drive),
						64'(want.left_drive));
				if (result_bus.right_drive !== want.right_drive)
					report_mismatch("right_drive", 64'(result_bus.right_drive),
						64'(want.right_drive));
				if (result_bus.timed_out !== want.timed_out)
					report_mismatch("timed_out", 64'(result_bus.timed_out),
						64'(want.timed_out));
				if (want.timed_out)
					timeouts_seen++;
			end
			results_seen++;
		end
	end

	// Send one beat: optional idle gap, then hold valid until the handshake.
	// Valid is left high on return; release_input, or an idle gap in the next send, lowers it.
	task automatic send_item(input odo_item_t it);
		odo_result_t r;
		begin
			@(negedge clk);
			while ($urandom_range(99) < gap_pct) begin
				item_bus.valid = 1'b0;
				@(negedge clk);
			end
			item_bus.op = it.op;
			item_bus.left_wheel_rate = it.left_rate;
			item_bus.right_wheel_rate = it.right_rate;
			item_bus.elapsed = it.elapsed;
			item_bus.cmd_linear = it.cmd_lin;
			item_bus.cmd_angular = it.cmd_ang;
			item_bus.valid = 1'b1;
			do
				@(posedge clk);
			while (!item_bus.ready);
			odometry_predict(it, r);
			pending_results.insert(pending_results.size(), r);
			if (it.op == ddo_pkg::OP_TICK)
				ticks_sent++;
			else
				commands_sent++;
		end
	endtask

	task automatic release_input();
		@(negedge clk);
		item_bus.valid = 1'b0;
	endtask

	// Hold the sender until every outstanding beat has come back
	task automatic drain_results();
		release_input();
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic write_reg(input logic [ddo_pkg::CFG_IDX_W-1:0] idx,
		input logic [23:0] value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			ddo_pkg::REG_WHEEL_RADIUS: geo_radius = value[15:0];
			ddo_pkg::REG_INV_WHEEL_SEP: geo_inv_sep = value;
			ddo_pkg::REG_HALF_WHEEL_SEP: geo_half_sep = value[15:0];
			ddo_pkg::REG_INV_WHEEL_RAD: geo_inv_radius = value;
			ddo_pkg::REG_CMD_TIMEOUT: geo_timeout = value[20:0];
			default: ;
		endcase
	endtask

	task automatic write_geometry(input logic [15:0] rad, input logic [23:0] isep,
		input logic [15:0] hsep, input logic [23:0] irad, input logic [20:0] tmo);
		write_reg(ddo_pkg::REG_WHEEL_RADIUS, {8'b0, rad});
		write_reg(ddo_pkg::REG_INV_WHEEL_SEP, isep);
		write_reg(ddo_pkg::REG_HALF_WHEEL_SEP, {8'b0, hsep});
		write_reg(ddo_pkg::REG_INV_WHEEL_RAD, irad);
		write_reg(ddo_pkg::REG_CMD_TIMEOUT, {3'b0, tmo});
	endtask

	function automatic odo_item_t tick(input logic signed [23:0] l, input logic signed [23:0] r,
		input logic [20:0] st);
		odo_item_t it;
		it.op = ddo_pkg::OP_TICK;
		it.left_rate = l;
		it.right_rate = r;
		it.elapsed = st;
		it.cmd_lin = 24'($urandom);
		it.cmd_ang = 24'($urandom);
		return it;
	endfunction

	function automatic odo_item_t command(input logic signed [23:0] lin,
		input logic signed [23:0] ang);
		odo_item_t it;
		it.op = ddo_pkg::OP_CMD;
		it.left_rate = 24'($urandom);
		it.right_rate = 24'($urandom);
		it.elapsed = 21'($urandom);
		it.cmd_lin = lin;
		it.cmd_ang = ang;
		return it;
	endfunction

	function automatic logic signed [23:0] random_rate();
		int sel;
		sel = $urandom_range(99);
		if (sel < 65)
			return 24'($signed($urandom_range(0, 262143)) - 131072);
		if (sel < 85)
			return 24'($signed($urandom_range(0, 4194303)) - 2097152);
		return 24'($urandom);
	endfunction

	function automatic logic [20:0] random_step();
		int sel;
		sel = $urandom_range(99);
		if (sel < 5)
			return '0;
		if (sel < 65)
			return 21'($urandom_range(1, 40000));
		if (sel < 88)
			return 21'($urandom_range(0, 1048576));
		return 21'($urandom);
	endfunction

	// Mostly ticks between occasional commands, so targets live long enough
	// to be driven and sometimes run past the timeout
	function automatic odo_item_t random_item();
		int sel;
		odo_item_t it;
		sel = $urandom_range(99);
		if (sel < 22) begin
			it = command(random_rate(), random_rate());
		end else if (sel < 32) begin
			// straight run: equal rates, no turn
			it = tick(random_rate(), 24'sd0, random_step());
			it.right_rate = it.left_rate;
		end else begin
			it = tick(random_rate(), random_rate(), random_step());
		end
		return it;
	endfunction

	// Directed extremes on the reset geometry
	task automatic test_directed_extremes();
		begin
			send_item(tick(24'sd0, 24'sd0, 21'd0));
			send_item(tick(24'sh7FFFFF, 24'sh7FFFFF, 21'd0));
			send_item(tick(24'sh800000, 24'sh800000, 21'd1048576));
			send_item(tick(24'sh7FFFFF, 24'sh800000, 21'd1048576));
			send_item(tick(24'sh800000, 24'sh7FFFFF, 21'h1FFFFF));
			send_item(command(24'sh7FFFFF, 24'sh7FFFFF));
			send_item(tick(24'sd65536, 24'sd65536, 21'd1000));
			send_item(command(24'sh800000, 24'sh7FFFFF));
			send_item(command(24'sh7FFFFF, 24'sh800000));
			send_item(command(24'sh800000, 24'sh800000));
			// idle time well under the limit, then past it, then held at the ceiling
			send_item(command(24'sd32768, 24'sd16384));
			send_item(tick(24'sd0, 24'sd100000, 21'd500000));
			send_item(tick(24'sd0, 24'sd100000, 21'd200000));
			send_item(tick(24'sd0, 24'sd100000, 21'h1FFFFF));
			send_item(tick(24'sd0, 24'sd100000, 21'h1FFFFF));
			// turn through every quadrant of the heading
			for (int i = 0; i < 6; i++)
				send_item(tick(-24'sd600000, 24'sd600000, 21'd1048576));
			send_item(command(24'sd0, 24'sd0));
			send_item(tick(24'sd12345, -24'sd54321, 21'd0));
			drain_results();
		end
	endtask

	// Geometry corner settings with a short burst each
	task automatic test_geometry_corners();
		begin
			write_geometry(16'hFFFF, 24'hFFFFFF, 16'hFFFF, 24'hFFFFFF, 21'h1FFFFF);
			send_item(command(24'sh7FFFFF, 24'sh800000));
			send_item(tick(24'sh7FFFFF, 24'sh800000, 21'h1FFFFF));
			send_item(tick(24'sh800000, 24'sh7FFFFF, 21'h1FFFFF));
			send_item(command(24'sh400000, 24'sh400000));
			send_item(tick(24'sd1, -24'sd1, 21'd1));
			drain_results();
			write_geometry(16'd0, 24'd0, 16'd0, 24'd0, 21'd0);
			send_item(command(24'sd500000, 24'sd500000));
			send_item(tick(24'sh7FFFFF, 24'sd3, 21'd7));
			send_item(tick(24'sd0, 24'sd0, 21'd0));
			drain_results();
		end
	endtask

	task automatic test_random_phase(input int gap, input int stall);
		begin
			gap_pct = gap;
			stall_pct = stall;
			for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
				send_item(random_item());
				// once in a while hold the sender until the pipe is empty
				if ($urandom_range(199) == 0)
					drain_results();
			end
			drain_results();
		end
	endtask

	task automatic randomise_geometry();
		write_geometry(16'($urandom), 24'($urandom_range(0, 1048575)), 16'($urandom),
			24'($urandom_range(0, 2097151)), 21'($urandom_range(20000, 1500000)));
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		item_bus.valid = 1'b0;
		item_bus.op = ddo_pkg::OP_TICK;
		item_bus.left_wheel_rate = '0;
		item_bus.right_wheel_rate = '0;
		item_bus.elapsed = '0;
		item_bus.cmd_linear = '0;
		item_bus.cmd_angular = '0;
		result_bus.ready = 1'b0;
		geo_radius = ddo_pkg::WHEEL_RADIUS_RST;
		geo_inv_sep = ddo_pkg::INV_WHEEL_SEP_RST;
		geo_half_sep = ddo_pkg::HALF_WHEEL_SEP_RST;
		geo_inv_radius = ddo_pkg::INV_WHEEL_RAD_RST;
		geo_timeout = ddo_pkg::CMD_TIMEOUT_RST;
		odo_x = '0;
		odo_y = '0;
		odo_heading = '0;
		odo_left_target = '0;
		odo_right_target = '0;
		odo_idle_time = '0;
		odo_lin_vel = '0;
		odo_ang_vel = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_extremes();
		test_geometry_corners();
		write_geometry(ddo_pkg::WHEEL_RADIUS_RST, ddo_pkg::INV_WHEEL_SEP_RST,
			ddo_pkg::HALF_WHEEL_SEP_RST, ddo_pkg::INV_WHEEL_RAD_RST,
			ddo_pkg::CMD_TIMEOUT_RST);
		test_random_phase(0, 0);
		randomise_geometry();
		test_random_phase(54, 0);
		write_geometry(16'hFFFF, 24'hFFFFFF, 16'hFFFF, 24'hFFFFFF, 21'd300000);
		test_random_phase(0, 54);
		randomise_geometry();
		test_random_phase(37, 37);

		$display("Covered %0d ticks and %0d commands, %0d results, %0d timeouts,",
			ticks_sent, commands_sent, results_seen, timeouts_seen);
		$display("under default, corner and random geometry with sender and receiver stalls");
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("%0d mismatches, %0d results never arrived", mismatches,
				pending_results.size());
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
